// ===== design/text_console_character_engine_top_macros.svh =====
// Assertion macros used by the text console engine sequencer.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcce_pkg.sv =====
// Shared constants and result type of the text console character engine.
package tcce_pkg;

    localparam int ROWS_DEF   = 25;
    localparam int COLS_DEF   = 80;
    localparam int CELL_W     = 16;
    localparam int TAB_STOP   = 8;
    localparam int TAB_MARGIN = 5;

    localparam logic [7:0] ATTR_RESET = 8'd15;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_FF      = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [10:0]       linear;
        logic [6:0]        col;
        logic [4:0]        row;
    } t_result;

endpackage

// ===== design/tcce_mem.sv =====
// Screen cell store: one write port, one read port with registered read data.
module tcce_mem
    import tcce_pkg::*;
#(
    parameter int DEPTH = ROWS_DEF * COLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [CELL_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [CELL_W-1:0]        o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/tcce_ctrl.sv =====
// Sequencer: cursor, attribute register, clear, scroll copy and cell reads.
`include "text_console_character_engine_top_macros.svh"

module tcce_ctrl
    import tcce_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [7:0]                      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [7:0]                      i_char,
    input  logic [4:0]                      i_read_row,
    input  logic [6:0]                      i_read_col,
    output logic                            o_res_valid,
    output t_result                         o_res,
    input  logic                            i_res_take,
    output logic                            o_mem_we,
    output logic [$clog2(ROWS*COLS)-1:0]    o_mem_waddr,
    output logic [CELL_W-1:0]               o_mem_wdata,
    output logic [$clog2(ROWS*COLS)-1:0]    o_mem_raddr,
    input  logic [CELL_W-1:0]               i_mem_rdata
);

    localparam int TOTAL     = ROWS * COLS;
    localparam int ADDR_W    = $clog2(TOTAL);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLS);
    localparam int COPY_LAST = (ROWS - 1) * COLS - 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_DONE   = 6'b000100,
        S_CLEAR  = 6'b001000,
        S_SCROLL = 6'b010000,
        S_BLANK  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [7:0]          r_attr;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic                r_cp_valid, n_cp_valid;
    logic                r_ff, n_ff;
    logic [ADDR_W-1:0]   r_cp_addr, n_cp_addr;
    logic                r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0]   r_cell, n_cell;

    logic                accept;
    logic                printable;
    logic                row_last;
    logic                col_last;
    logic                rd_ok;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   cur_addr;
    logic [COL_W:0]      tab_next;
    logic                tab_ok;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign printable = (i_char >= PRINT_LO) && (i_char <= PRINT_HI);
    assign row_last  = (r_row == ROW_W'(ROWS - 1));
    assign col_last  = (r_col == COL_W'(COLS - 1));
    assign cur_addr  = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLS)) + ADDR_W'(r_col);

    assign rd_ok   = (7'(i_read_row) < 7'(ROWS)) && (8'(i_read_col) < 8'(COLS));
    assign rd_addr = rd_ok ? ADDR_W'(ADDR_W'(i_read_row) * ADDR_W'(COLS)) + ADDR_W'(i_read_col)
                           : '0;

    // Next tab stop from the column rounded down to a stop.
    assign tab_ok   = (COL_W+1)'(r_col) < (COL_W+1)'(COLS - TAB_MARGIN);
    assign tab_next = ((COL_W+1)'(r_col) & ~(COL_W+1)'(TAB_STOP - 1))
                      + (COL_W+1)'(TAB_STOP);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_cp_valid  = r_cp_valid;
        n_ff        = r_ff;
        n_cp_addr   = r_cp_addr;
        n_rd_ok     = r_rd_ok;
        n_cell      = r_cell;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt;
        o_mem_wdata = '0;
        o_mem_raddr = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                if (r_cnt == ADDR_W'(TOTAL - 1)) begin
                    n_state = r_ff ? S_DONE : S_IDLE;
                    n_ff    = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cell  = '0;
                    n_state = S_DONE;
                    if (i_action) begin
                        n_rd_ok     = rd_ok;
                        o_mem_raddr = rd_addr;
                        n_state     = S_READ;
                    end else if (printable) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = cur_addr;
                        o_mem_wdata = {r_attr, i_char};
                        if (col_last) begin
                            n_col = '0;
                            if (row_last) begin
                                n_cnt      = '0;
                                n_cp_valid = 1'b0;
                                n_state    = S_SCROLL;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        unique case (i_char)
                            CH_BS: begin
                                if (r_col != '0) begin
                                    n_col = r_col - 1'b1;
                                end
                            end
                            CH_TAB: begin
                                if (tab_ok) begin
                                    n_col = (tab_next > (COL_W+1)'(COLS - 1))
                                          ? COL_W'(COLS - 1) : COL_W'(tab_next);
                                end
                            end
                            CH_LF: begin
                                n_col = '0;
                                if (row_last) begin
                                    n_cnt      = '0;
                                    n_cp_valid = 1'b0;
                                    n_state    = S_SCROLL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end
                            CH_FF: begin
                                n_row   = '0;
                                n_col   = '0;
                                n_cnt   = '0;
                                n_ff    = 1'b1;
                                n_state = S_CLEAR;
                            end
                            CH_CR: begin
                                n_col = '0;
                            end
                            default: begin
                                n_col = r_col;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                n_cell  = r_rd_ok ? i_mem_rdata : '0;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // Read one row ahead and write the data back in the following cycle.
                o_mem_raddr = r_cnt + ADDR_W'(COLS);
                n_cp_addr   = r_cnt;
                n_cp_valid  = 1'b1;
                if (r_cp_valid) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_cp_addr;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_cnt == ADDR_W'(COPY_LAST)) begin
                    n_cnt   = ADDR_W'(COPY_LAST + 1);
                    n_state = S_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_BLANK: begin
                o_mem_we = 1'b1;
                if (r_cp_valid) begin
                    // Drain the last copy write first.
                    o_mem_waddr = r_cp_addr;
                    o_mem_wdata = i_mem_rdata;
                    n_cp_valid  = 1'b0;
                end else if (r_cnt == ADDR_W'(TOTAL - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_row      <= '0;
            r_col      <= '0;
            r_cnt      <= '0;
            r_cp_valid <= 1'b0;
            r_ff       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cnt      <= n_cnt;
            r_cp_valid <= n_cp_valid;
            r_ff       <= n_ff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        r_rd_ok   <= n_rd_ok;
        r_cell    <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.row       = 5'(r_row);
    assign o_res.col       = 7'(r_col);
    assign o_res.linear    = 11'(cur_addr);
    assign o_res.cell_data = r_cell;

    `TCCE_ASSERT_SAME(a_cursor_range, 1'b1, (r_row < ROWS) && (r_col < COLS), "cursor out of range")
    `TCCE_ASSERT_SAME(a_waddr_range, o_mem_we, o_mem_waddr < TOTAL, "write beyond screen store")
    `TCCE_ASSERT_SAME(a_copy_owner, r_cp_valid, (r_state == S_SCROLL) || (r_state == S_BLANK), "copy write pending outside scroll")
    `TCCE_ASSERT_NEXT(a_take_idle, o_res_valid && i_res_take, r_state == S_IDLE, "no return to idle after result")

endmodule

// ===== design/text_console_character_engine_top.sv =====
// Top level of the text console character engine: ports and output register.

// A put item (tuser 0) for a plain or moving byte goes from acceptance straight
// to the result state; a read item (tuser 1) first passes the read state, for
// the registered read of the cell store. Everything goes through the single
// write port of the ROWS x COLS cell store: a scroll copies ROWS-1 rows one cell
// per cycle and then blanks the bottom row, and a form feed clears ROWS*COLS
// cells before its result. After reset the same clearing pass runs with
// s_axis_tready low; attribute writes are taken at any time. A finished result
// waits in the output register while the next item is accepted.
module text_console_character_engine_top
    import tcce_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
    input  logic [23:0] s_axis_tdata,
    // action [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cursor_row [4:0], cursor_col [11:5], cursor_linear [22:12],
    // cell_data [38:23], zero [39]
    output logic [39:0] m_axis_tdata
);

    localparam int TOTAL  = ROWS * COLS;
    localparam int ADDR_W = $clog2(TOTAL);

    logic                res_valid;
    logic                res_take;
    t_result             res;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CELL_W-1:0]   mem_rdata;
    logic                r_ovalid;
    logic [39:0]         r_odata;

    tcce_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_char      (s_axis_tdata[7:0]),
        .i_read_row  (s_axis_tdata[12:8]),
        .i_read_col  (s_axis_tdata[19:13]),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tcce_mem #(
        .DEPTH (TOTAL)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Load a result when the output register is empty or being drained.
    assign res_take = res_valid && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_odata <= {1'b0, res.cell_data, res.linear, res.col, res.row};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text console character engine.
module tb;
    import tcce_pkg::*;

    localparam int ROWS            = ROWS_DEF;
    localparam int COLS            = COLS_DEF;
    localparam int DIR_N           = 23;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 188;
    localparam int CYCLE_LIMIT     = 20_000_000;
    localparam logic [7:0] CH_VT   = 8'd11;

    typedef enum logic {ACT_PUT = 1'b0, ACT_READ = 1'b1} t_action;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        t_action     act;
        logic [7:0]  code;
        logic [4:0]  rr;
        logic [6:0]  rc;
        logic        typed;
        t_result     res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
    logic [23:0] s_axis_tdata = '0;
    // action [0]
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // cursor_row [4:0], cursor_col [11:5], cursor_linear [22:12],
    // cell_data [38:23], zero [39]
    logic [39:0] m_axis_tdata;

    // shadow of the screen, cursor and attribute
    logic [15:0] screen_shadow [ROWS*COLS];
    int          row_shadow;
    int          col_shadow;
    logic [7:0]  attr_shadow;

    t_result     cursor_expect_q [$];
    t_dir_row    dir_tab [DIR_N];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    text_console_character_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Move to column 0 of the next row, scrolling on the last row.
    function automatic void advance_line();
        if (row_shadow >= ROWS - 1) begin
            for (int k = 0; k < (ROWS - 1) * COLS; k++)
                screen_shadow[k] = screen_shadow[k + COLS];
            for (int k = (ROWS - 1) * COLS; k < ROWS * COLS; k++)
                screen_shadow[k] = '0;
            row_shadow = ROWS - 1;
        end else begin
            row_shadow = row_shadow + 1;
        end
        col_shadow = 0;
    endfunction

    function automatic t_result console_apply(t_action act, logic [7:0] code,
                                              logic [4:0] rr, logic [6:0] rc);
        t_result res;
        int      nxt;
        res = '0;
        if (act == ACT_PUT) begin
            case (code)
                CH_BS: begin
                    if (col_shadow != 0)
                        col_shadow = col_shadow - 1;
                end
                CH_TAB: begin
                    if (col_shadow < COLS - TAB_MARGIN) begin
                        nxt = col_shadow + (TAB_STOP - (col_shadow % TAB_STOP));
                        col_shadow = (nxt > COLS - 1) ? COLS - 1 : nxt;
                    end
                end
                CH_LF: advance_line();
                CH_FF: begin
                    for (int k = 0; k < ROWS * COLS; k++)
                        screen_shadow[k] = '0;
                    row_shadow = 0;
                    col_shadow = 0;
                end
                CH_CR: col_shadow = 0;
                default: begin
                    if (code >= PRINT_LO && code <= PRINT_HI) begin
                        screen_shadow[row_shadow * COLS + col_shadow] = {attr_shadow, code};
                        if (col_shadow >= COLS - 1)
                            advance_line();
                        else
                            col_shadow = col_shadow + 1;
                    end
                end
            endcase
        end else if (rr < ROWS && rc < COLS) begin
            res.cell_data = screen_shadow[int'(rr) * COLS + int'(rc)];
        end
        res.row    = 5'(row_shadow);
        res.col    = 7'(col_shadow);
        res.linear = 11'(row_shadow * COLS + col_shadow);
        return res;
    endfunction

    function automatic t_result exp_at(int r, int c, int lin, logic [15:0] data);
        t_result res;
        res.row       = 5'(r);
        res.col       = 7'(c);
        res.linear    = 11'(lin);
        res.cell_data = data;
        return res;
    endfunction

    task automatic send_item(t_action act, logic [7:0] code, logic [4:0] rr,
                             logic [6:0] rc, t_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, rc, rr, code};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        cursor_expect_q.push_back(want);
    endtask

    // Drain all results, then write the attribute while the block is idle.
    task automatic write_attr(logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (cursor_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        attr_shadow = value;
    endtask

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default:   begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    // Mostly text with line control, some reads near the cursor, a little noise.
    task automatic pick_item(output t_action act, output logic [7:0] code,
                             output logic [4:0] rr, output logic [6:0] rc);
        int sel;
        int k;
        rr   = 5'($urandom);
        rc   = 7'($urandom);
        code = 8'($urandom);
        sel  = $urandom_range(99);
        if (sel < 22) begin
            act = ACT_READ;
            k = $urandom_range(9);
            if (k < 6) begin
                rr = 5'(row_shadow);
                rc = 7'($urandom_range(COLS - 1));
            end else if (k < 9) begin
                rr = 5'($urandom_range(ROWS - 1));
                rc = 7'($urandom_range(COLS - 1));
            end
        end else begin
            act = ACT_PUT;
            sel = $urandom_range(999);
            if (sel < 2)
                code = CH_FF;
            else if (sel < 82)
                code = CH_LF;
            else if (sel < 162)
                code = CH_TAB;
            else if (sel < 232)
                code = CH_BS;
            else if (sel < 282)
                code = CH_CR;
            else if (sel < 342) begin
                // anything the block must ignore
                while ((code >= PRINT_LO && code <= PRINT_HI) || code == CH_BS ||
                       code == CH_TAB || code == CH_LF || code == CH_FF || code == CH_CR)
                    code = 8'($urandom);
            end else
                code = 8'($urandom_range(PRINT_HI, PRINT_LO));
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[38:0]);
            if (cursor_expect_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: row %0d col %0d lin %0d cell %h",
                             got.row, got.col, got.linear, got.cell_data);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                want = cursor_expect_q.pop_front();
                if (got.row != want.row || got.col != want.col ||
                    got.linear != want.linear || got.cell_data != want.cell_data) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected %0d/%0d/%0d/%h, got %0d/%0d/%0d/%h",
                                 want.row, want.col, want.linear, want.cell_data,
                                 got.row, got.col, got.linear, got.cell_data);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_result     pred;
        t_action     act;
        logic [7:0]  code;
        logic [4:0]  rr;
        logic [6:0]  rc;
        logic [7:0]  attr;

        for (int k = 0; k < ROWS * COLS; k++)
            screen_shadow[k] = '0;
        row_shadow  = 0;
        col_shadow  = 0;
        attr_shadow = ATTR_RESET;

        dir_tab[0]  = '{ACT_READ, 8'd0,     5'd0,  7'd0,   1'b1, exp_at(0, 0, 0, 16'h0000)};
        dir_tab[1]  = '{ACT_READ, 8'd0,     5'd24, 7'd79,  1'b1, exp_at(0, 0, 0, 16'h0000)};
        dir_tab[2]  = '{ACT_READ, 8'd255,   5'd31, 7'd127, 1'b1, exp_at(0, 0, 0, 16'h0000)};
        dir_tab[3]  = '{ACT_PUT,  CH_BS,    5'd0,  7'd0,   1'b1, exp_at(0, 0, 0, 16'h0000)};
        dir_tab[4]  = '{ACT_PUT,  PRINT_LO, 5'd0,  7'd0,   1'b1, exp_at(0, 1, 1, 16'h0000)};
        dir_tab[5]  = '{ACT_PUT,  PRINT_HI, 5'd0,  7'd0,   1'b1, exp_at(0, 2, 2, 16'h0000)};
        dir_tab[6]  = '{ACT_READ, 8'd0,     5'd0,  7'd1,   1'b1,
                        exp_at(0, 2, 2, {ATTR_RESET, PRINT_HI})};
        dir_tab[7]  = '{ACT_PUT,  8'd255,   5'd31, 7'd127, 1'b1, exp_at(0, 2, 2, 16'h0000)};
        dir_tab[8]  = '{ACT_PUT,  8'd0,     5'd0,  7'd0,   1'b1, exp_at(0, 2, 2, 16'h0000)};
        dir_tab[9]  = '{ACT_PUT,  8'd127,   5'd0,  7'd0,   1'b1, exp_at(0, 2, 2, 16'h0000)};
        dir_tab[10] = '{ACT_PUT,  CH_VT,    5'd0,  7'd0,   1'b1, exp_at(0, 2, 2, 16'h0000)};
        dir_tab[11] = '{ACT_PUT,  8'd31,    5'd0,  7'd0,   1'b1, exp_at(0, 2, 2, 16'h0000)};
        dir_tab[12] = '{ACT_PUT,  CH_TAB,   5'd0,  7'd0,   1'b1, exp_at(0, 8, 8, 16'h0000)};
        dir_tab[13] = '{ACT_PUT,  CH_TAB,   5'd0,  7'd0,   1'b1, exp_at(0, 16, 16, 16'h0000)};
        dir_tab[14] = '{ACT_PUT,  CH_BS,    5'd0,  7'd0,   1'b1, exp_at(0, 15, 15, 16'h0000)};
        dir_tab[15] = '{ACT_PUT,  CH_CR,    5'd0,  7'd0,   1'b1, exp_at(0, 0, 0, 16'h0000)};
        dir_tab[16] = '{ACT_PUT,  CH_LF,    5'd0,  7'd0,   1'b1, exp_at(1, 0, 80, 16'h0000)};
        dir_tab[17] = '{ACT_PUT,  8'h5A,    5'd0,  7'd0,   1'b0, '0};
        dir_tab[18] = '{ACT_READ, 8'd0,     5'd1,  7'd0,   1'b0, '0};
        dir_tab[19] = '{ACT_READ, 8'd0,     5'd25, 7'd0,   1'b1, exp_at(1, 1, 81, 16'h0000)};
        dir_tab[20] = '{ACT_READ, 8'd0,     5'd0,  7'd80,  1'b1, exp_at(1, 1, 81, 16'h0000)};
        dir_tab[21] = '{ACT_PUT,  CH_FF,    5'd0,  7'd0,   1'b1, exp_at(0, 0, 0, 16'h0000)};
        dir_tab[22] = '{ACT_READ, 8'd0,     5'd0,  7'd1,   1'b1, exp_at(0, 0, 0, 16'h0000)};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        for (int i = 0; i < DIR_N; i++) begin
            pred = console_apply(dir_tab[i].act, dir_tab[i].code, dir_tab[i].rr, dir_tab[i].rc);
            send_item(dir_tab[i].act, dir_tab[i].code, dir_tab[i].rr, dir_tab[i].rc,
                      dir_tab[i].typed ? dir_tab[i].res : pred);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:          attr = 8'h00;
                1:          attr = 8'hFF;
                PHASES - 1: attr = ATTR_RESET;
                default:    attr = 8'($urandom);
            endcase
            write_attr(attr);
            set_idling(t_idle_mode'(p % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick_item(act, code, rr, rc);
                pred = console_apply(act, code, rr, rc);
                send_item(act, code, rr, rc, pred);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (cursor_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
